>>> hdl/ktc_pkg.sv
// shared types and constants for the keyed block transposition cipher
package ktc_pkg;

	localparam int KEY_W = 40;
	localparam logic [7:0] PAD_CHAR = 8'h2A;

	// configuration register indexes
	localparam logic CFG_KEY_LETTERS = 1'b0;
	localparam logic CFG_DECRYPT_MODE = 1'b1;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_t;

	typedef struct packed {
		logic [7:0] cipher_byte;
		logic       block_last;
	} out_t;

	typedef enum logic [0:0] {
		ST_COLLECT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic advance;
	} ctrl_cmd_t;

	typedef struct packed {
		logic block_done;
		logic emit_last;
	} dp_status_t;

endpackage

>>> hdl/ktc_ctrl.sv
// controller state machine: collects bytes, then emits a permuted block
module ktc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	output ktc_pkg::ctrl_cmd_t     cmd,
	input  ktc_pkg::dp_status_t    status
);

	ktc_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ktc_pkg::ST_COLLECT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ktc_pkg::ST_COLLECT: begin
				if (in_valid && status.block_done) begin
					state_nxt = ktc_pkg::ST_EMIT;
				end
			end
			ktc_pkg::ST_EMIT: begin
				if (!out_stall && status.emit_last) begin
					state_nxt = ktc_pkg::ST_COLLECT;
				end
			end
			default: state_nxt = ktc_pkg::ST_COLLECT;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		cmd.load    = 1'b0;
		cmd.advance = 1'b0;
		unique case (state_q)
			ktc_pkg::ST_COLLECT: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ktc_pkg::ST_EMIT: begin
				out_valid   = 1'b1;
				cmd.advance = !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

>>> hdl/ktc_datapath.sv
// datapath: config registers, block buffer, key ranking and output select
module ktc_datapath #(
	parameter int KEY_LEN = 5,
	localparam int IDX_W = $clog2(KEY_LEN),
	localparam int CNT_W = $clog2(KEY_LEN + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ktc_pkg::ctrl_cmd_t          cmd,
	output ktc_pkg::dp_status_t         status,
	input  ktc_pkg::in_t                in_data,
	output ktc_pkg::out_t               out_data,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [ktc_pkg::KEY_W-1:0]   cfg_data
);

	logic [KEY_LEN*8-1:0] key_q;
	logic                 mode_q;
	logic [7:0]           blk_q [KEY_LEN];
	logic [IDX_W-1:0]     fill_q;
	logic [CNT_W-1:0]     used_q;
	logic [IDX_W-1:0]     slot_q;

	logic [7:0]       key_byte [KEY_LEN];
	logic [IDX_W-1:0] rank [KEY_LEN];
	logic [IDX_W-1:0] src_enc;
	logic [IDX_W-1:0] src;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ktc_pkg::CFG_KEY_LETTERS:  key_q  <= cfg_data[KEY_LEN*8-1:0];
				ktc_pkg::CFG_DECRYPT_MODE: mode_q <= cfg_data[0];
				default:                   mode_q <= mode_q;
			endcase
		end
	end

	assign status.block_done = (fill_q == IDX_W'(KEY_LEN - 1)) || in_data.end_of_text;
	assign status.emit_last  = (slot_q == IDX_W'(KEY_LEN - 1));

	// fill and emit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			used_q <= '0;
			slot_q <= '0;
		end else begin
			if (cmd.load) begin
				if (status.block_done) begin
					fill_q <= '0;
					used_q <= CNT_W'(fill_q) + CNT_W'(1);
				end else begin
					fill_q <= fill_q + IDX_W'(1);
				end
			end
			if (cmd.advance) begin
				slot_q <= status.emit_last ? '0 : slot_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			blk_q[fill_q] <= in_data.text_byte;
		end
	end

	// rank of each key position, ties broken by position
	always_comb begin
		for (int i = 0; i < KEY_LEN; i++) begin
			key_byte[i] = key_q[8*i +: 8];
		end
		for (int p = 0; p < KEY_LEN; p++) begin
			rank[p] = '0;
			for (int q = 0; q < KEY_LEN; q++) begin
				if ((key_byte[q] < key_byte[p]) || ((key_byte[q] == key_byte[p]) && (q < p))) begin
					rank[p] = rank[p] + IDX_W'(1);
				end
			end
		end
	end

	// encrypt reads the position whose rank equals the output slot
	always_comb begin
		src_enc = '0;
		for (int p = 0; p < KEY_LEN; p++) begin
			if (rank[p] == slot_q) begin
				src_enc = IDX_W'(p);
			end
		end
	end

	assign src = mode_q ? rank[slot_q] : src_enc;

	assign out_data.cipher_byte = (CNT_W'(src) < used_q) ? blk_q[src] : ktc_pkg::PAD_CHAR;
	assign out_data.block_last  = status.emit_last;

endmodule

>>> hdl/keyed_block_transposition_cipher_unit.sv
// top level of the keyed block transposition cipher
//
// usage:
// - input channel (in_valid / in_stall / in_data) takes one text byte per
//   transaction; end_of_text marks the last byte of a text
// - bytes collect into a block of KEY_LEN entries; a block closes when it is
//   full or when a byte with end_of_text arrives, padding the rest with '*'
// - a closed block leaves on the output channel (out_valid / out_stall /
//   out_data) as KEY_LEN transactions, block_last set on the final one
// - encrypt: slot r carries the byte at the key position of rank r;
//   decrypt (decrypt_mode = 1) applies the inverse permutation
// - output timing: first byte of a block shows in the cycle after the closing
//   input transaction; one output byte per cycle while out_stall is low
// - the single block buffer is filled and then read out in turn, so no new
//   block is collected while the previous one is being emitted
// - in_stall is high for the whole emit phase; a stalled output byte holds
// - reset clears key, mode and fill count; the block buffer is not cleared
// - configuration is written through cfg_we / cfg_index / cfg_data while idle
module keyed_block_transposition_cipher_unit #(
	parameter int KEY_LEN = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  ktc_pkg::in_t                in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output ktc_pkg::out_t               out_data,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [ktc_pkg::KEY_W-1:0]   cfg_data
);

	// command and status between controller and datapath
	ktc_pkg::ctrl_cmd_t  cmd;
	ktc_pkg::dp_status_t status;

	// sequencing: collect phase, then emit phase
	ktc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// storage, key ranking and byte selection
	ktc_datapath #(
		.KEY_LEN (KEY_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

>>> hdl/ktc_checker.sv
// port-level checker for the cipher unit and its bind
module ktc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input ktc_pkg::in_t                in_data,
	input logic                        out_valid,
	input logic                        out_stall,
	input ktc_pkg::out_t               out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// no input transaction while a block is being emitted
	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken during emit");

	// idle output means the block is collecting
	a_collect_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while not emitting");

	// end of text closes the block at once
	a_eot_emit: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.end_of_text |=> out_valid)
		else $error("end of text did not start emit");

	// emit stops after the last byte of a block
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.block_last |=> !out_valid)
		else $error("emit continued past block end");

endmodule

bind keyed_block_transposition_cipher_unit ktc_checker u_ktc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
